@@ src/vchc_pkg.sv @@
// Package for the movie container header checker.
// Widths, header constants, error codes and the view type shared by the modules.
// No dependencies.
package vchc_pkg;

   localparam int MAX_PARTS = 16;

   localparam int INDEX_W = 12;
   localparam int WORD_W  = 32;
   localparam int CODE_W  = 4;
   localparam int NUM_HDR_WORDS = 8;

   localparam logic [WORD_W-1:0]  HDR_MAGIC   = 32'h3144_4956;
   localparam logic [WORD_W-1:0]  HDR_VERSION = 32'd1;
   localparam logic [WORD_W-1:0]  HDR_BYTES   = 32'd48;
   localparam logic [INDEX_W-1:0] HDR_BYTES_IDX = 12'd48;
   localparam int                 ENTRY_BYTES = 8;
   localparam logic [INDEX_W-1:0] BYTE_LIMIT =
      INDEX_W'(48 + ENTRY_BYTES * MAX_PARTS);
   localparam logic [WORD_W-1:0]  MAX_PARTS_WORD = WORD_W'(MAX_PARTS);

   // Word positions in the header
   localparam logic [INDEX_W-3:0] WIDX_MAGIC   = 10'd0;
   localparam logic [INDEX_W-3:0] WIDX_VERSION = 10'd1;
   localparam logic [INDEX_W-3:0] WIDX_FIELDS  = 10'd2;
   localparam logic [INDEX_W-3:0] WIDX_TABLE   = 10'd12;

   // Header word slots
   localparam int SLOT_FRAMES = 4;
   localparam int SLOT_PARTS  = 5;
   localparam int SLOT_OFFSET = 7;

   // Error codes, first failing check wins
   localparam logic [CODE_W-1:0] ERR_OK          = 4'd0;
   localparam logic [CODE_W-1:0] ERR_SHORT       = 4'd1;
   localparam logic [CODE_W-1:0] ERR_MAGIC       = 4'd2;
   localparam logic [CODE_W-1:0] ERR_VERSION     = 4'd3;
   localparam logic [CODE_W-1:0] ERR_ZERO_FIELD  = 4'd4;
   localparam logic [CODE_W-1:0] ERR_PARTS_OVER  = 4'd5;
   localparam logic [CODE_W-1:0] ERR_OFFSET      = 4'd6;
   localparam logic [CODE_W-1:0] ERR_TABLE_SHORT = 4'd7;
   localparam logic [CODE_W-1:0] ERR_BAD_PART    = 4'd8;

   typedef logic [WORD_W-1:0] word_type;

   // Parser state after the current byte, before the end-of-buffer clear
   typedef struct packed {
      logic [INDEX_W-1:0]                 len;
      word_type [NUM_HDR_WORDS-1:0]       words;
      logic [CODE_W-1:0]                  first_error;
   } parse_view_type;

endpackage

@@ src/vchc_in_stage.sv @@
// Input register of the header checker: holds one byte transfer until the
// parser takes it. Depends on vchc_pkg.
module vchc_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_last_byte,
   input  logic       take,
   output logic       held_valid,
   output logic [7:0] held_byte,
   output logic       held_last
);
   import vchc_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       load;

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_byte_value;
         last_ff <= req_last_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_last  = last_ff;

endmodule

@@ src/vchc_parse.sv @@
// Header parser: word assembly, header word store, part entry checks.
// Depends on vchc_pkg.
module vchc_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              byte_value,
   input  logic                    last_byte,
   output vchc_pkg::parse_view_type view
);
   import vchc_pkg::*;

   logic [INDEX_W-1:0]  byte_index_ff, byte_index_in;
   word_type            word_shift_ff, word_shift_in;
   word_type [NUM_HDR_WORDS-1:0] header_words_ff, header_words_in;
   word_type            entry_first_ff, entry_first_in;
   logic [CODE_W-1:0]   first_error_ff, first_error_in;

   logic                active;
   logic                word_done;
   logic [INDEX_W-3:0]  widx;
   logic [INDEX_W-3:0]  rel;
   word_type            entry_num;
   word_type            frames;
   logic                bad;

   always_comb begin
      active         = byte_index_ff < BYTE_LIMIT;
      byte_index_in  = byte_index_ff;
      word_shift_in  = word_shift_ff;
      header_words_in = header_words_ff;
      entry_first_in = entry_first_ff;
      first_error_in = first_error_ff;
      widx           = byte_index_ff[INDEX_W-1:2];
      rel            = widx - WIDX_TABLE;
      entry_num      = WORD_W'(rel[INDEX_W-3:1]);
      frames         = header_words_ff[SLOT_FRAMES];
      word_done      = 1'b0;
      bad            = 1'b0;

      if (active) begin
         word_shift_in = {byte_value, word_shift_ff[WORD_W-1:8]};
         byte_index_in = byte_index_ff + 1'b1;
         word_done     = byte_index_ff[1:0] == 2'd3;
      end

      bad = (word_shift_in == '0) || (entry_first_ff >= frames)
            || (word_shift_in > (frames - entry_first_ff));

      if (word_done) begin
         if (widx == WIDX_MAGIC) begin
            if (word_shift_in != HDR_MAGIC) first_error_in = ERR_MAGIC;
         end else if (widx == WIDX_VERSION) begin
            if (word_shift_in != HDR_VERSION && first_error_ff == ERR_OK)
               first_error_in = ERR_VERSION;
         end else if (widx >= WIDX_TABLE) begin
            if (!rel[0]) begin
               entry_first_in = word_shift_in;
            end else if (entry_num < header_words_ff[SLOT_PARTS]) begin
               if (bad && first_error_ff == ERR_OK) first_error_in = ERR_BAD_PART;
            end
         end
         for (int k = 0; k < NUM_HDR_WORDS; k++) begin
            if (widx == WIDX_FIELDS + (INDEX_W-2)'(k)) header_words_in[k] = word_shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         byte_index_ff   <= '0;
         word_shift_ff   <= '0;
         header_words_ff <= '0;
         entry_first_ff  <= '0;
         first_error_ff  <= ERR_OK;
      end else if (step) begin
         byte_index_ff   <= byte_index_in;
         word_shift_ff   <= word_shift_in;
         header_words_ff <= header_words_in;
         entry_first_ff  <= entry_first_in;
         first_error_ff  <= first_error_in;
      end
   end

   assign view.len         = byte_index_in;
   assign view.words       = header_words_in;
   assign view.first_error = first_error_in;

endmodule

@@ src/vchc_verdict.sv @@
// Verdict logic and result register of the header checker.
// Depends on vchc_pkg.
module vchc_verdict (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  vchc_pkg::parse_view_type view,
   output logic                    out_free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_error_code,
   output logic [31:0]             rsp_coded_w,
   output logic [31:0]             rsp_coded_h,
   output logic [31:0]             rsp_fps_num,
   output logic [31:0]             rsp_fps_den,
   output logic [31:0]             rsp_frame_total,
   output logic [31:0]             rsp_part_total,
   output logic [31:0]             rsp_max_unit,
   output logic [31:0]             rsp_data_offset
);
   import vchc_pkg::*;

   logic                 valid_ff, valid_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   word_type [NUM_HDR_WORDS-1:0] words_ff;

   word_type parts, frames;
   word_type want_offset;
   word_type table_end;
   logic     any_zero;

   always_comb begin
      parts       = view.words[SLOT_PARTS];
      frames      = view.words[SLOT_FRAMES];
      want_offset = HDR_BYTES + {parts[WORD_W-4:0], 3'b000} + {frames[WORD_W-4:0], 3'b000};
      table_end   = HDR_BYTES + {parts[WORD_W-4:0], 3'b000};
      any_zero    = 1'b0;
      for (int k = 0; k < SLOT_OFFSET; k++) begin
         if (view.words[k] == '0) any_zero = 1'b1;
      end

      priority if (view.len < HDR_BYTES_IDX) begin
         code_in = ERR_SHORT;
      end else if (view.first_error == ERR_MAGIC || view.first_error == ERR_VERSION) begin
         code_in = view.first_error;
      end else if (any_zero) begin
         code_in = ERR_ZERO_FIELD;
      end else if (parts > MAX_PARTS_WORD) begin
         code_in = ERR_PARTS_OVER;
      end else if (view.words[SLOT_OFFSET] != want_offset) begin
         code_in = ERR_OFFSET;
      end else if (WORD_W'(view.len) < table_end) begin
         code_in = ERR_TABLE_SHORT;
      end else if (view.first_error == ERR_BAD_PART) begin
         code_in = ERR_BAD_PART;
      end else begin
         code_in = ERR_OK;
      end
   end

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff  <= code_in;
         words_ff <= view.words;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_error_code  = code_ff;
   assign rsp_coded_w     = words_ff[0];
   assign rsp_coded_h     = words_ff[1];
   assign rsp_fps_num     = words_ff[2];
   assign rsp_fps_den     = words_ff[3];
   assign rsp_frame_total = words_ff[4];
   assign rsp_part_total  = words_ff[5];
   assign rsp_max_unit    = words_ff[6];
   assign rsp_data_offset = words_ff[7];

endmodule

@@ src/video_container_header_check_core.sv @@
// Movie container header checker. Bytes of a header arrive one per req_
// transfer, in file order, little-endian words; req_last_byte marks the end of
// the buffer. The block takes one byte every clock cycle unless a last byte
// waits for a busy result register: a byte is held in the input register, then
// the parser folds it into the header state, and on the flagged byte the
// verdict is written into the result register at that same edge. Only
// the last byte of a buffer yields a rsp_ transfer; it carries the first failing
// check (short, magic, version, zero field, too many parts, data offset, table
// short, bad part entry; 0 when good) and header words 2..9 as received, zero
// where a word never arrived. Part entries are checked as they stream by and
// are not kept. Bytes past the part table for the largest part count are
// ignored. After the result the parser is back in its reset state, ready for
// the next buffer. A stalled rsp_ side holds off only the next last byte and
// the bytes behind it; earlier bytes keep flowing.
module video_container_header_check_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_error_code,
   output logic [31:0] rsp_coded_w,
   output logic [31:0] rsp_coded_h,
   output logic [31:0] rsp_fps_num,
   output logic [31:0] rsp_fps_den,
   output logic [31:0] rsp_frame_total,
   output logic [31:0] rsp_part_total,
   output logic [31:0] rsp_max_unit,
   output logic [31:0] rsp_data_offset
);
   import vchc_pkg::*;

   logic           held_valid;
   logic [7:0]     held_byte;
   logic           held_last;
   logic           out_free;
   logic           step;
   parse_view_type view;

   // A byte moves on unless it closes a buffer and the result register is busy
   assign step = held_valid && (!held_last || out_free);

   vchc_in_stage u_in (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .take           (step),
      .held_valid     (held_valid),
      .held_byte      (held_byte),
      .held_last      (held_last)
   );

   vchc_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_value (held_byte),
      .last_byte  (held_last),
      .view       (view)
   );

   // Verdict is formed from the parser state including the flagged byte
   vchc_verdict u_verdict (
      .clock           (clock),
      .reset           (reset),
      .load            (step && held_last),
      .view            (view),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_error_code  (rsp_error_code),
      .rsp_coded_w     (rsp_coded_w),
      .rsp_coded_h     (rsp_coded_h),
      .rsp_fps_num     (rsp_fps_num),
      .rsp_fps_den     (rsp_fps_den),
      .rsp_frame_total (rsp_frame_total),
      .rsp_part_total  (rsp_part_total),
      .rsp_max_unit    (rsp_max_unit),
      .rsp_data_offset (rsp_data_offset)
   );

endmodule
